// ===== rtl/core/tlfba_pkg.sv =====
// Package with the shared types and constants of the timed block allocator.
`timescale 1ns / 1ps

package tlfba_pkg;

    // Timestamp and register widths
    localparam int TIME_W    = 32;
    localparam int TIMEOUT_W = 16;
    localparam int ID_W      = 16;
    localparam int GRANT_W   = 9;
    localparam int STATUS_W  = 2;

    // One store entry: held flag above the last access time
    localparam int ENTRY_W   = TIME_W + 1;

    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd600;

    // Register map: index of each register, taken from paddr[2]
    localparam logic REG_IDLE_TIMEOUT = 1'b0;

    // Action codes
    localparam logic ACT_ALLOCATE = 1'b0;
    localparam logic ACT_ACCESS   = 1'b1;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_ALLOCATED = 2'd0;
    localparam logic [STATUS_W-1:0] ST_GRANTED   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_REFUSED   = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

    typedef struct packed {
        logic              action;
        logic [TIME_W-1:0] request_time;
        logic [ID_W-1:0]   block_id;
    } req_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [GRANT_W-1:0]  granted_block;
    } rsp_t;

    typedef enum logic [4:0] {
        FSM_CLEAR = 5'b00001,
        FSM_IDLE  = 5'b00010,
        FSM_SWEEP = 5'b00100,
        FSM_DRAIN = 5'b01000,
        FSM_DONE  = 5'b10000
    } fsm_t;

endpackage

// ===== rtl/core/tlfba_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps

module tlfba_ram #(
    parameter int WIDTH = 33,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/timed_lowest_free_block_allocator.sv =====
// Top level of the timed lowest-free block allocator.
`timescale 1ns / 1ps

// Hands out block numbers 1..NUM_BLOCKS and takes them back after idle_timeout
// time units without access. Each request beat carries a timestamp and either
// an allocate or an access action; exactly one result beat comes back per
// request. All block state (held flag and last access time) lives in one
// synchronous RAM of NUM_BLOCKS entries, which a single sweep per request
// reads, updates and writes back: expiry, the lowest-free search and the
// access check all happen in that one pass. A request passes through the
// sweep state, which reads every entry in turn, a drain state for the last
// read data, and a done state that posts the result once the output
// register is free, before idle takes the next request. Only one request
// is in work at a time, but a new request is taken while the previous
// result still waits in the output register. After reset the block first
// clears the RAM, one entry per cycle, and holds req_stall high meanwhile;
// configuration writes are taken at any time. Write idle_timeout only while
// no request is in work.

module timed_lowest_free_block_allocator #(
    parameter int NUM_BLOCKS = 256
) (
    input  logic                 clk,
    input  logic                 rst_n,

    // Request channel
    input  logic                 req_valid,
    output logic                 req_stall,
    input  tlfba_pkg::req_t      req,

    // Result channel
    output logic                 rsp_valid,
    input  logic                 rsp_stall,
    output tlfba_pkg::rsp_t      rsp,

    // Configuration port
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    localparam int AW   = $clog2(NUM_BLOCKS);
    localparam int IDXW = tlfba_pkg::ID_W + 1;   // holds any block number and its index

    localparam logic [AW-1:0] LAST_IDX = AW'(NUM_BLOCKS - 1);

    // ------------------------------------------------------------------
    // Configuration register
    // ------------------------------------------------------------------
    logic [tlfba_pkg::TIMEOUT_W-1:0] timeout_reg;
    logic                            cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= tlfba_pkg::TIMEOUT_RESET;
        end
        else if (cfg_wr && paddr[2] == tlfba_pkg::REG_IDLE_TIMEOUT)
        begin
            timeout_reg <= pwdata[tlfba_pkg::TIMEOUT_W-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == tlfba_pkg::REG_IDLE_TIMEOUT)
        begin
            prdata = 32'(timeout_reg);
        end
    end

    // ------------------------------------------------------------------
    // Control state
    // ------------------------------------------------------------------
    tlfba_pkg::fsm_t  state_reg, state_next;
    logic [AW-1:0]    idx_reg, idx_next;       // sweep / clear address
    logic             pv_reg, pv_next;         // read data valid next cycle
    logic [AW-1:0]    pa_reg;                  // address of that read data
    logic             found_reg, found_next;   // allocate placed a block
    logic             hit_reg, hit_next;       // access found a held block
    logic             rsp_valid_reg, rsp_valid_next;
    logic             req_accept;
    logic             rsp_load;

    // Request and result payload
    tlfba_pkg::req_t                 req_reg;
    logic [tlfba_pkg::GRANT_W-1:0]   gnt_reg, gnt_next;
    tlfba_pkg::rsp_t                 rsp_reg;

    // RAM interface
    logic                            ram_we;
    logic [AW-1:0]                   ram_waddr;
    logic [tlfba_pkg::ENTRY_W-1:0]   ram_wdata;
    logic [tlfba_pkg::ENTRY_W-1:0]   ram_rdata;

    // Entry update for the read data of this cycle
    logic                            ent_held;
    logic [tlfba_pkg::TIME_W-1:0]    ent_time;
    logic [tlfba_pkg::TIME_W:0]      expiry_sum;
    logic                            ent_live;
    logic [IDXW-1:0]                 target_idx;
    logic [IDXW-1:0]                 pa_plus_one;
    logic                            take_alloc;
    logic                            take_access;

    assign req_stall  = (state_reg != tlfba_pkg::FSM_IDLE);
    assign req_accept = req_valid & ~req_stall;
    assign rsp_valid  = rsp_valid_reg;
    assign rsp        = rsp_reg;

    tlfba_ram #(
        .WIDTH (tlfba_pkg::ENTRY_W),
        .DEPTH (NUM_BLOCKS)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (idx_reg),
        .rdata (ram_rdata)
    );

    // Expire first, then either claim the first free entry or restamp the
    // addressed one. Block number zero maps to an all-ones index and numbers
    // beyond NUM_BLOCKS to indexes the sweep never reaches, so both refuse.
    always_comb
    begin
        ent_held    = ram_rdata[tlfba_pkg::TIME_W];
        ent_time    = ram_rdata[tlfba_pkg::TIME_W-1:0];
        expiry_sum  = {1'b0, ent_time} + (tlfba_pkg::TIME_W + 1)'(timeout_reg);
        ent_live    = ent_held && (expiry_sum > {1'b0, req_reg.request_time});
        target_idx  = IDXW'(req_reg.block_id) - IDXW'(1);
        pa_plus_one = IDXW'(pa_reg) + IDXW'(1);
        take_alloc  = pv_reg && req_reg.action == tlfba_pkg::ACT_ALLOCATE
                      && !found_reg && !ent_live;
        take_access = pv_reg && req_reg.action == tlfba_pkg::ACT_ACCESS
                      && IDXW'(pa_reg) == target_idx && ent_live;
    end

    always_comb
    begin
        ram_we    = pv_reg;
        ram_waddr = pa_reg;
        ram_wdata = {ent_live, ent_time};
        if (take_alloc || take_access)
        begin
            ram_wdata = {1'b1, req_reg.request_time};
        end
        if (state_reg == tlfba_pkg::FSM_CLEAR)
        begin
            ram_we    = 1'b1;
            ram_waddr = idx_reg;
            ram_wdata = '0;
        end
    end

    // Sequencer: clear after reset, then one full sweep per request
    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        pv_next        = 1'b0;
        found_next     = found_reg | take_alloc;
        hit_next       = hit_reg | take_access;
        gnt_next       = gnt_reg;
        rsp_valid_next = rsp_valid_reg & rsp_stall;
        rsp_load       = 1'b0;

        if (take_alloc)
        begin
            gnt_next = pa_plus_one[tlfba_pkg::GRANT_W-1:0];
        end

        case (state_reg)
            tlfba_pkg::FSM_CLEAR:
            begin
                idx_next = idx_reg + AW'(1);
                if (idx_reg == LAST_IDX)
                begin
                    idx_next   = '0;
                    state_next = tlfba_pkg::FSM_IDLE;
                end
            end
            tlfba_pkg::FSM_IDLE:
            begin
                if (req_accept)
                begin
                    idx_next   = '0;
                    found_next = 1'b0;
                    hit_next   = 1'b0;
                    gnt_next   = '0;
                    state_next = tlfba_pkg::FSM_SWEEP;
                end
            end
            tlfba_pkg::FSM_SWEEP:
            begin
                pv_next  = 1'b1;
                idx_next = idx_reg + AW'(1);
                if (idx_reg == LAST_IDX)
                begin
                    idx_next   = '0;
                    state_next = tlfba_pkg::FSM_DRAIN;
                end
            end
            tlfba_pkg::FSM_DRAIN:
            begin
                state_next = tlfba_pkg::FSM_DONE;
            end
            tlfba_pkg::FSM_DONE:
            begin
                // Post the result once the output register is free
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_load       = 1'b1;
                    rsp_valid_next = 1'b1;
                    state_next     = tlfba_pkg::FSM_IDLE;
                end
            end
            default:
            begin
                state_next = tlfba_pkg::FSM_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tlfba_pkg::FSM_CLEAR;
            idx_reg       <= '0;
            pv_reg        <= 1'b0;
            found_reg     <= 1'b0;
            hit_reg       <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            pv_reg        <= pv_next;
            found_reg     <= found_next;
            hit_reg       <= hit_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Payload: request hold, read address pipe, result beat
    always_ff @(posedge clk)
    begin
        pa_reg  <= idx_reg;
        gnt_reg <= gnt_next;
        if (req_accept)
        begin
            req_reg <= req;
        end
        if (rsp_load)
        begin
            if (req_reg.action == tlfba_pkg::ACT_ALLOCATE)
            begin
                rsp_reg.status        <= found_reg ? tlfba_pkg::ST_ALLOCATED
                                                   : tlfba_pkg::ST_FULL;
                rsp_reg.granted_block <= found_reg ? gnt_reg : '0;
            end
            else
            begin
                rsp_reg.status        <= hit_reg ? tlfba_pkg::ST_GRANTED
                                                 : tlfba_pkg::ST_REFUSED;
                rsp_reg.granted_block <= '0;
            end
        end
    end

endmodule

// ===== sim/tb_timed_lowest_free_block_allocator.sv =====
// Self-checking testbench for the timed lowest-free block allocator.
`timescale 1ns / 1ps

// A short table of directed request beats comes first. It covers the first
// allocations after reset, access to block zero, to blocks past the top and to
// blocks not held, stamps near the top of the time range, and timestamps that
// go backward. Randomized phases follow, each with its own idle_timeout and its
// own idle and stall mix: zero timeout, one, the full 16-bit range, the reset
// value and random values. Two fill phases keep time nearly still so that every
// block gets held and allocate runs out of blocks. A behavioral allocator model
// in this file tracks held flags and stamps and predicts every result beat.
module tb_timed_lowest_free_block_allocator;

    localparam int NUM_BLOCKS  = 256;
    localparam int N_DIRECTED  = 22;
    localparam int N_PHASES    = 8;
    // Long enough for the block to finish two requests and block its input
    localparam int HOLD_CYCLES = 2000;

    localparam logic [2:0] ADDR_IDLE_TIMEOUT = {tlfba_pkg::REG_IDLE_TIMEOUT, 2'b00};
    localparam logic [2:0] ADDR_UNMAPPED     = {~tlfba_pkg::REG_IDLE_TIMEOUT, 2'b00};

    typedef struct {
        tlfba_pkg::req_t beat;
        bit              typed;    // expected result written in below
        tlfba_pkg::rsp_t want;
    } dir_row_t;

    typedef struct {
        int unsigned                     items;
        int unsigned                     send_idle;
        int unsigned                     recv_stall;
        bit                              rand_timeout;
        logic [tlfba_pkg::TIMEOUT_W-1:0] timeout;
        bit                              fill;
        bit                              rebase;
        logic [tlfba_pkg::TIME_W-1:0]    base;
    } phase_t;

    logic            clk       = 1'b0;
    logic            rst_n     = 1'b0;
    logic            req_valid = 1'b0;
    logic            req_stall;
    tlfba_pkg::req_t req       = '0;
    logic            rsp_valid;
    logic            rsp_stall = 1'b0;
    tlfba_pkg::rsp_t rsp;
    logic            psel      = 1'b0;
    logic            penable   = 1'b0;
    logic            pwrite    = 1'b0;
    logic [2:0]      paddr     = '0;
    logic [31:0]     pwdata    = '0;
    logic [31:0]     prdata;
    logic            pready;

    // Allocator model state
    logic                            held_map  [NUM_BLOCKS];
    logic [tlfba_pkg::TIME_W-1:0]    stamp_map [NUM_BLOCKS];
    logic [tlfba_pkg::TIMEOUT_W-1:0] timeout_reg;
    logic [tlfba_pkg::TIME_W-1:0]    now_time;

    tlfba_pkg::rsp_t pending_rsp_q [$];
    int unsigned     mismatches     = 0;
    int unsigned     send_idle_pct  = 0;
    int unsigned     recv_stall_pct = 0;
    int unsigned     hold_orders    = 0;
    int unsigned     hold_served    = 0;
    int unsigned     hold_left      = 0;

    dir_row_t dir_rows [N_DIRECTED] = '{
        // First two allocations after reset
        '{'{tlfba_pkg::ACT_ALLOCATE, 32'd0,         16'd0},    1'b1,
          '{tlfba_pkg::ST_ALLOCATED, 9'd1}},
        '{'{tlfba_pkg::ACT_ALLOCATE, 32'd0,         16'd0},    1'b1,
          '{tlfba_pkg::ST_ALLOCATED, 9'd2}},
        '{'{tlfba_pkg::ACT_ACCESS,   32'd10,        16'd1},    1'b1,
          '{tlfba_pkg::ST_GRANTED,   9'd0}},
        // Block zero, past the top, all ones, not held
        '{'{tlfba_pkg::ACT_ACCESS,   32'd10,        16'd0},    1'b1,
          '{tlfba_pkg::ST_REFUSED,   9'd0}},
        '{'{tlfba_pkg::ACT_ACCESS,   32'd10,        16'd257},  1'b1,
          '{tlfba_pkg::ST_REFUSED,   9'd0}},
        '{'{tlfba_pkg::ACT_ACCESS,   32'd10,        16'hFFFF}, 1'b1,
          '{tlfba_pkg::ST_REFUSED,   9'd0}},
        '{'{tlfba_pkg::ACT_ACCESS,   32'd10,        16'd3},    1'b1,
          '{tlfba_pkg::ST_REFUSED,   9'd0}},
        '{'{tlfba_pkg::ACT_ACCESS,   32'd10,        16'd256},  1'b1,
          '{tlfba_pkg::ST_REFUSED,   9'd0}},
        // Expiry exactly at stamp plus timeout; id ignored on allocate
        '{'{tlfba_pkg::ACT_ALLOCATE, 32'd600,       16'hFFFF}, 1'b0,
          '{tlfba_pkg::ST_ALLOCATED, 9'd0}},
        '{'{tlfba_pkg::ACT_ACCESS,   32'd600,       16'd2},    1'b0,
          '{tlfba_pkg::ST_ALLOCATED, 9'd0}},
        '{'{tlfba_pkg::ACT_ALLOCATE, 32'd1209,      16'd0},    1'b0,
          '{tlfba_pkg::ST_ALLOCATED, 9'd0}},
        '{'{tlfba_pkg::ACT_ACCESS,   32'd1199,      16'd2},    1'b0,
          '{tlfba_pkg::ST_ALLOCATED, 9'd0}},
        // Stamps near the top: the expiry sum must not wrap
        '{'{tlfba_pkg::ACT_ALLOCATE, 32'hFFFF_FE00, 16'h5555}, 1'b0,
          '{tlfba_pkg::ST_ALLOCATED, 9'd0}},
        '{'{tlfba_pkg::ACT_ACCESS,   32'hFFFF_FFFF, 16'd1},    1'b0,
          '{tlfba_pkg::ST_ALLOCATED, 9'd0}},
        '{'{tlfba_pkg::ACT_ALLOCATE, 32'hFFFF_FFFF, 16'hAAAA}, 1'b0,
          '{tlfba_pkg::ST_ALLOCATED, 9'd0}},
        // Time steps back to zero
        '{'{tlfba_pkg::ACT_ALLOCATE, 32'd0,         16'd0},    1'b0,
          '{tlfba_pkg::ST_ALLOCATED, 9'd0}},
        '{'{tlfba_pkg::ACT_ACCESS,   32'd5,         16'd1},    1'b0,
          '{tlfba_pkg::ST_ALLOCATED, 9'd0}},
        '{'{tlfba_pkg::ACT_ACCESS,   32'd100,       16'h5555}, 1'b1,
          '{tlfba_pkg::ST_REFUSED,   9'd0}},
        '{'{tlfba_pkg::ACT_ACCESS,   32'd100,       16'hAAAA}, 1'b1,
          '{tlfba_pkg::ST_REFUSED,   9'd0}},
        '{'{tlfba_pkg::ACT_ALLOCATE, 32'h5555_5555, 16'd0},    1'b0,
          '{tlfba_pkg::ST_ALLOCATED, 9'd0}},
        '{'{tlfba_pkg::ACT_ALLOCATE, 32'hAAAA_AAAA, 16'd0},    1'b0,
          '{tlfba_pkg::ST_ALLOCATED, 9'd0}},
        '{'{tlfba_pkg::ACT_ACCESS,   32'hAAAA_AAAA, 16'd3},    1'b0,
          '{tlfba_pkg::ST_ALLOCATED, 9'd0}}
    };

    // items, sender idle %, receiver stall %, random timeout, timeout, fill,
    // rebase time, base time
    phase_t phase_plan [N_PHASES] = '{
        '{250, 0,  0,  1'b0, tlfba_pkg::TIMEOUT_RESET, 1'b0, 1'b1, 32'd100},
        '{200, 88, 0,  1'b0, 16'd0,                    1'b0, 1'b0, 32'd0},
        '{200, 0,  88, 1'b0, 16'd1,                    1'b0, 1'b0, 32'd0},
        '{400, 0,  0,  1'b0, 16'hFFFF,                 1'b1, 1'b0, 32'd0},
        '{250, 27, 27, 1'b1, 16'd0,                    1'b0, 1'b1, 32'hFFFF_0000},
        '{200, 0,  0,  1'b0, 16'hFFFF,                 1'b1, 1'b1, 32'hFFFF_FF00},
        '{200, 88, 0,  1'b1, 16'd0,                    1'b0, 1'b1, 32'h8000_0000},
        '{200, 0,  88, 1'b1, 16'd0,                    1'b0, 1'b0, 32'd0}
    };

    timed_lowest_free_block_allocator #(
        .NUM_BLOCKS (NUM_BLOCKS)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Release expired blocks, then allocate the lowest free one or restamp
    // the block that is accessed. Return the result beat this request causes.
    function automatic tlfba_pkg::rsp_t allocate_or_touch(tlfba_pkg::req_t r);
        tlfba_pkg::rsp_t              res;
        logic [tlfba_pkg::TIME_W:0]   expiry;
        logic                         found;
        int unsigned                  k;
        for (int i = 0; i < NUM_BLOCKS; i++)
        begin
            // Form the sum one bit wider so a stamp near the top never wraps
            expiry = {1'b0, stamp_map[i]}
                   + {{(tlfba_pkg::TIME_W + 1 - tlfba_pkg::TIMEOUT_W){1'b0}}, timeout_reg};
            if (held_map[i] && expiry <= {1'b0, r.request_time})
                held_map[i] = 1'b0;
        end
        res.granted_block = '0;
        if (r.action == tlfba_pkg::ACT_ALLOCATE)
        begin
            res.status = tlfba_pkg::ST_FULL;
            found      = 1'b0;
            for (int i = 0; i < NUM_BLOCKS; i++)
            begin
                if (!found && !held_map[i])
                begin
                    found             = 1'b1;
                    held_map[i]       = 1'b1;
                    stamp_map[i]      = r.request_time;
                    res.status        = tlfba_pkg::ST_ALLOCATED;
                    res.granted_block = tlfba_pkg::GRANT_W'(i + 1);
                end
            end
        end
        else
        begin
            res.status = tlfba_pkg::ST_REFUSED;
            if (r.block_id >= 1 && r.block_id <= NUM_BLOCKS)
            begin
                k = r.block_id - 1;
                if (held_map[k])
                begin
                    stamp_map[k] = r.request_time;
                    res.status   = tlfba_pkg::ST_GRANTED;
                end
            end
        end
        return res;
    endfunction

    // Build one random request. Time mostly creeps forward in steps scaled to
    // the timeout, with rare jumps past it and rare steps backward. In fill
    // mode time nearly stands still and most beats allocate, so every block
    // gets held and allocate runs dry.
    function automatic tlfba_pkg::req_t make_random_request(bit fill_mode);
        tlfba_pkg::req_t r;
        int unsigned     pick;
        int unsigned     start;
        logic            found;
        pick = $urandom_range(999);
        if (fill_mode)
        begin
            if (pick < 2)
                now_time = now_time + 32'(timeout_reg) + $urandom_range(1, 50);
            else
                now_time = now_time + $urandom_range(0, 3);
        end
        else if (pick < 30)
            now_time = now_time - $urandom_range(0, 32'(timeout_reg) + 1);
        else if (pick < 100)
            now_time = now_time + 32'(timeout_reg)
                     + $urandom_range(0, 32'(timeout_reg) + 1);
        else
            now_time = now_time + $urandom_range(0, 32'(timeout_reg) / 4 + 1);
        r.request_time = now_time;

        if ($urandom_range(99) < (fill_mode ? 90 : 45))
        begin
            r.action   = tlfba_pkg::ACT_ALLOCATE;
            r.block_id = tlfba_pkg::ID_W'($urandom());
        end
        else
        begin
            r.action = tlfba_pkg::ACT_ACCESS;
            pick     = $urandom_range(99);
            if (pick < 55)
            begin
                // Aim at a block that is held right now, searching from a
                // random start
                start      = $urandom_range(NUM_BLOCKS - 1);
                r.block_id = tlfba_pkg::ID_W'(start + 1);
                found      = 1'b0;
                for (int i = 0; i < NUM_BLOCKS; i++)
                begin
                    if (!found && held_map[(start + i) % NUM_BLOCKS])
                    begin
                        found      = 1'b1;
                        r.block_id = tlfba_pkg::ID_W'((start + i) % NUM_BLOCKS + 1);
                    end
                end
            end
            else if (pick < 80)
                r.block_id = tlfba_pkg::ID_W'($urandom_range(1, NUM_BLOCKS));
            else if (pick < 90)
            begin
                case ($urandom_range(2))
                    0:       r.block_id = '0;
                    1:       r.block_id = tlfba_pkg::ID_W'(NUM_BLOCKS);
                    default: r.block_id = tlfba_pkg::ID_W'(NUM_BLOCKS + 1);
                endcase
            end
            else
                r.block_id = tlfba_pkg::ID_W'($urandom());
        end
        return r;
    endfunction

    task automatic log_mismatch(string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t: %s", $realtime, msg);
    endtask

    // Offer one request beat, with a random idle gap first, and hold it until
    // it is taken. Call at a rising edge; return at the edge that took it,
    // with valid still high.
    task automatic send_request(tlfba_pkg::req_t r, bit typed, tlfba_pkg::rsp_t typed_rsp);
        tlfba_pkg::rsp_t want;
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        req       <= r;
        req_valid <= 1'b1;
        do
            @(posedge clk);
        while (req_stall);
        want = allocate_or_touch(r);
        if (typed)
            want = typed_rsp;
        pending_rsp_q.push_back(want);
    endtask

    // Drop valid and wait for every pending result to come back
    task automatic wait_until_drained();
        req_valid <= 1'b0;
        while (pending_rsp_q.size() != 0)
            @(posedge clk);
    endtask

    // Setup cycle, then access cycle; the register takes the data at the edge
    // that ends the access cycle
    task automatic write_register(logic [2:0] addr, logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr[2] == tlfba_pkg::REG_IDLE_TIMEOUT)
            timeout_reg = data[tlfba_pkg::TIMEOUT_W-1:0];
    endtask

    // Result side: stall at the phase's rate, or for a long hold-off when
    // the stimulus orders one
    always @(posedge clk)
    begin
        if (hold_orders != hold_served)
        begin
            hold_served = hold_orders;
            hold_left   = HOLD_CYCLES;
        end
        if (hold_left != 0)
        begin
            hold_left--;
            rsp_stall <= 1'b1;
        end
        else
            rsp_stall <= (recv_stall_pct != 0) && ($urandom_range(99) < recv_stall_pct);
    end

    // Compare each result beat with the oldest pending prediction
    always @(posedge clk)
    begin
        tlfba_pkg::rsp_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (pending_rsp_q.size() == 0)
                log_mismatch($sformatf("result beat with none pending: status %0d block %0d",
                                       rsp.status, rsp.granted_block));
            else
            begin
                want = pending_rsp_q.pop_front();
                if (rsp.status !== want.status || rsp.granted_block !== want.granted_block)
                    log_mismatch($sformatf(
                        "mismatch: expected status %0d block %0d, got status %0d block %0d",
                        want.status, want.granted_block, rsp.status, rsp.granted_block));
            end
        end
    end

    initial
    begin
        tlfba_pkg::rsp_t typed_rsp;
        phase_t          ph;
        logic [15:0]     new_timeout;
        for (int i = 0; i < NUM_BLOCKS; i++)
        begin
            held_map[i]  = 1'b0;
            stamp_map[i] = '0;
        end
        timeout_reg = tlfba_pkg::TIMEOUT_RESET;
        now_time    = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed table under the reset timeout; the block stalls its input
        // while it clears its store
        for (int d = 0; d < N_DIRECTED; d++)
        begin
            typed_rsp = dir_rows[d].want;
            send_request(dir_rows[d].beat, dir_rows[d].typed, typed_rsp);
        end
        now_time = dir_rows[N_DIRECTED-1].beat.request_time;

        for (int p = 0; p < N_PHASES; p++)
        begin
            ph = phase_plan[p];
            wait_until_drained();
            // A write to an unmapped index must leave the timeout alone
            if (p == 0)
                write_register(ADDR_UNMAPPED, $urandom());
            new_timeout = ph.rand_timeout ? 16'($urandom_range(1, 4000)) : ph.timeout;
            write_register(ADDR_IDLE_TIMEOUT, {16'($urandom()), new_timeout});
            send_idle_pct  = ph.send_idle;
            recv_stall_pct = ph.recv_stall;
            if (ph.rebase)
                now_time = ph.base;
            // Hold off the result side while requests keep coming, so the
            // output register fills and the input stalls
            if (ph.fill && hold_orders == 0)
                hold_orders++;
            typed_rsp = '0;
            repeat (ph.items)
                send_request(make_random_request(ph.fill), 1'b0, typed_rsp);
        end

        wait_until_drained();
        // Leave room for a stray beat from a request still in the sweep
        repeat (NUM_BLOCKS + 8) @(posedge clk);
        if (mismatches == 0 && pending_rsp_q.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
